/* hdl/bcv_pkg.sv */
package bcv_pkg;

  // Field widths
  localparam int VOLT_W   = 13;
  localparam int CHARGE_W = 16;
  localparam int KIND_W   = 3;

  // Curve set dimensions
  localparam int NUM_POINTS = 8;
  localparam int NUM_KINDS  = 5;

  localparam int CURVE_W = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
  localparam int PT_W    = $clog2(NUM_POINTS);
  localparam int SEG_W   = (NUM_POINTS > 2) ? $clog2(NUM_POINTS - 1) : 1;

  // rise * dv, and the reciprocal used for the segment-width divide
  localparam int PROD_W      = VOLT_W + CHARGE_W;
  localparam int RECIP_W     = 32;
  localparam int RECIP_SHIFT = 32;
  localparam int WIDE_W      = PROD_W + RECIP_W;

  localparam logic [CHARGE_W-1:0] FULL_CHARGE = CHARGE_W'(32768);

  typedef logic [VOLT_W-1:0]   mv_row_t    [NUM_POINTS];
  typedef logic [CHARGE_W-1:0] q15_row_t   [NUM_POINTS];
  typedef logic [RECIP_W-1:0]  recip_row_t [NUM_POINTS-1];

  // Curve voltages in mV
  localparam mv_row_t CURVE_MV [NUM_KINDS] = '{
    '{13'd2800, 13'd3000, 13'd3100, 13'd3150, 13'd3250, 13'd3300, 13'd3400, 13'd3600},
    '{13'd2800, 13'd3000, 13'd3100, 13'd3150, 13'd3250, 13'd3300, 13'd3400, 13'd3600},
    '{13'd2000, 13'd2100, 13'd2300, 13'd2400, 13'd2500, 13'd2600, 13'd2900, 13'd3000},
    '{13'd2800, 13'd3000, 13'd3100, 13'd3150, 13'd3250, 13'd3300, 13'd3400, 13'd3600},
    '{13'd2000, 13'd2100, 13'd2300, 13'd2400, 13'd2500, 13'd2600, 13'd2900, 13'd3000}
  };

  // Curve charges in Q1.15
  localparam q15_row_t CURVE_Q15 [NUM_KINDS] = '{
    '{16'd0, 16'd3277, 16'd6554, 16'd13107, 16'd19661, 16'd26214, 16'd29491, 16'd32768},
    '{16'd0, 16'd3277, 16'd6554, 16'd13107, 16'd19661, 16'd26214, 16'd29491, 16'd32768},
    '{16'd0, 16'd3277, 16'd6554, 16'd13107, 16'd19661, 16'd26214, 16'd29491, 16'd32768},
    '{16'd0, 16'd3277, 16'd6554, 16'd13107, 16'd19661, 16'd26214, 16'd29491, 16'd32768},
    '{16'd0, 16'd3277, 16'd6554, 16'd13107, 16'd19661, 16'd26214, 16'd29491, 16'd32768}
  };

  // floor(2^32 / segment width), one per segment
  localparam recip_row_t SEG_RECIP [NUM_KINDS] = '{
    '{32'd21474836, 32'd42949672, 32'd85899345, 32'd42949672,
      32'd85899345, 32'd42949672, 32'd21474836},
    '{32'd21474836, 32'd42949672, 32'd85899345, 32'd42949672,
      32'd85899345, 32'd42949672, 32'd21474836},
    '{32'd42949672, 32'd21474836, 32'd42949672, 32'd42949672,
      32'd42949672, 32'd14316557, 32'd42949672},
    '{32'd21474836, 32'd42949672, 32'd85899345, 32'd42949672,
      32'd85899345, 32'd42949672, 32'd21474836},
    '{32'd42949672, 32'd21474836, 32'd42949672, 32'd42949672,
      32'd42949672, 32'd14316557, 32'd42949672}
  };

endpackage

/* hdl/battery_charge_from_voltage.sv */
// Battery state of charge from a voltage sample, by piecewise-linear lookup.
//
// Input channel: in_valid / in_stall with voltage_mv (mV, unsigned).
// Output channel: out_valid / out_stall with charge (Q1.15, 32768 = full).
// A transaction happens on a rising edge with valid high and stall low.
// Configuration: cfg_we writes cfg_wdata into the battery kind register, which
// picks the curve; kinds past the last curve use curve 0. Write only while idle.
//
// Six register stages: compare against the curve points, pick the segment,
// multiply rise by offset, multiply by the width reciprocal, multiply back for
// the remainder check, then correct and add the segment base in the output
// register. One transaction per cycle is taken in steady state while the
// receiver does not stall.
// When the receiver stalls, each stage holds unless the stage after it has room;
// in_stall rises only once every stage holds a transaction.
// Synchronous reset empties the pipeline and sets the battery kind to 0.
module battery_charge_from_voltage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bcv_pkg::KIND_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bcv_pkg::VOLT_W-1:0]     voltage_mv,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bcv_pkg::CHARGE_W-1:0]   charge
);
  import bcv_pkg::*;

  logic [CURVE_W-1:0] kind_sel;

  // stage 1: point compares
  logic                  s1_valid;
  logic [NUM_POINTS-1:0] s1_ge;
  logic                  s1_low;
  logic [VOLT_W-1:0]     s1_v;
  logic [CURVE_W-1:0]    s1_kind;

  // stage 2: segment terms
  logic                  s2_valid;
  logic [VOLT_W-1:0]     s2_dv;
  logic [CHARGE_W-1:0]   s2_rise;
  logic [CHARGE_W-1:0]   s2_clow;
  logic [VOLT_W-1:0]     s2_width;
  logic [RECIP_W-1:0]    s2_recip;

  // stage 3: rise * dv
  logic                  s3_valid;
  logic [PROD_W-1:0]     s3_prod;
  logic [CHARGE_W-1:0]   s3_clow;
  logic [VOLT_W-1:0]     s3_width;
  logic [RECIP_W-1:0]    s3_recip;

  // stage 4: quotient estimate
  logic                  s4_valid;
  logic [CHARGE_W-1:0]   s4_q;
  logic [PROD_W-1:0]     s4_prod;
  logic [CHARGE_W-1:0]   s4_clow;
  logic [VOLT_W-1:0]     s4_width;

  // stage 5: estimate * width
  logic                  s5_valid;
  logic [PROD_W-1:0]     s5_back;
  logic [CHARGE_W-1:0]   s5_q;
  logic [PROD_W-1:0]     s5_prod;
  logic [CHARGE_W-1:0]   s5_clow;
  logic [VOLT_W-1:0]     s5_width;

  // stage advance: a stage loads when it is empty or its contents move on
  logic adv1, adv2, adv3, adv4, adv5, adv6;

  assign adv6     = !out_valid || !out_stall;
  assign adv5     = !s5_valid  || adv6;
  assign adv4     = !s4_valid  || adv5;
  assign adv3     = !s3_valid  || adv4;
  assign adv2     = !s2_valid  || adv3;
  assign adv1     = !s1_valid  || adv2;
  assign in_stall = !adv1;

  // Battery kind register, reduced to a curve index on write
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_sel <= '0;
    end else if (cfg_we) begin
      if ({1'b0, cfg_wdata} < (KIND_W+1)'(NUM_KINDS)) begin
        kind_sel <= CURVE_W'(cfg_wdata);
      end else begin
        kind_sel <= '0;
      end
    end
  end

  // Stage 1 compares
  logic [NUM_POINTS-1:0] ge_next;
  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      ge_next[i] = (voltage_mv >= CURVE_MV[kind_sel][i]);
    end
  end

  // Stage 2: last segment whose low point is at or below v
  logic [SEG_W-1:0]    seg;
  logic [PT_W-1:0]     pt_lo;
  logic [PT_W-1:0]     pt_hi;
  logic [VOLT_W-1:0]   mv_lo;
  logic [VOLT_W-1:0]   mv_hi;
  logic [CHARGE_W-1:0] q_lo;
  logic [CHARGE_W-1:0] q_hi;
  logic [VOLT_W-1:0]   width_raw;

  always_comb begin
    seg = '0;
    for (int i = 1; i < NUM_POINTS - 1; i++) begin
      if (s1_ge[i]) begin
        seg = SEG_W'(i);
      end
    end
  end

  assign pt_lo     = PT_W'(seg);
  assign pt_hi     = pt_lo + PT_W'(1);
  assign mv_lo     = CURVE_MV[s1_kind][pt_lo];
  assign mv_hi     = CURVE_MV[s1_kind][pt_hi];
  assign q_lo      = CURVE_Q15[s1_kind][pt_lo];
  assign q_hi      = CURVE_Q15[s1_kind][pt_hi];
  assign width_raw = mv_hi - mv_lo;

  logic [VOLT_W-1:0]   dv_next;
  logic [CHARGE_W-1:0] rise_next;
  logic [CHARGE_W-1:0] clow_next;
  logic [VOLT_W-1:0]   width_next;
  logic [RECIP_W-1:0]  recip_next;

  // Saturated ends and a zero-width segment collapse to a constant base
  always_comb begin
    dv_next    = s1_v - mv_lo;
    rise_next  = q_hi - q_lo;
    clow_next  = q_lo;
    width_next = width_raw;
    recip_next = SEG_RECIP[s1_kind][seg];
    if (s1_low || s1_ge[NUM_POINTS-1] || (width_raw == '0)) begin
      dv_next    = '0;
      rise_next  = '0;
      width_next = VOLT_W'(1);
      recip_next = '0;
      if (s1_low) begin
        clow_next = '0;
      end else if (s1_ge[NUM_POINTS-1]) begin
        clow_next = FULL_CHARGE;
      end
    end
  end

  // Stage 4 estimate: floor(prod * recip / 2^32), low by at most one
  logic [WIDE_W-1:0] wide_prod;
  assign wide_prod = WIDE_W'(s3_prod) * WIDE_W'(s3_recip);

  // Output stage: one correction step
  logic [PROD_W-1:0]   rem;
  logic                bump;
  assign rem  = s5_prod - s5_back;
  assign bump = (rem >= PROD_W'(s5_width));

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid  <= in_valid;
      if (adv2) s2_valid  <= s1_valid;
      if (adv3) s3_valid  <= s2_valid;
      if (adv4) s4_valid  <= s3_valid;
      if (adv5) s5_valid  <= s4_valid;
      if (adv6) out_valid <= s5_valid;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_ge   <= ge_next;
      s1_low  <= (voltage_mv <= CURVE_MV[kind_sel][0]);
      s1_v    <= voltage_mv;
      s1_kind <= kind_sel;
    end
    if (adv2) begin
      s2_dv    <= dv_next;
      s2_rise  <= rise_next;
      s2_clow  <= clow_next;
      s2_width <= width_next;
      s2_recip <= recip_next;
    end
    if (adv3) begin
      s3_prod  <= PROD_W'(s2_rise) * PROD_W'(s2_dv);
      s3_clow  <= s2_clow;
      s3_width <= s2_width;
      s3_recip <= s2_recip;
    end
    if (adv4) begin
      s4_q     <= wide_prod[RECIP_SHIFT +: CHARGE_W];
      s4_prod  <= s3_prod;
      s4_clow  <= s3_clow;
      s4_width <= s3_width;
    end
    if (adv5) begin
      s5_back  <= PROD_W'(s4_q) * PROD_W'(s4_width);
      s5_q     <= s4_q;
      s5_prod  <= s4_prod;
      s5_clow  <= s4_clow;
      s5_width <= s4_width;
    end
    if (adv6) begin
      charge <= s5_clow + s5_q + CHARGE_W'(bump);
    end
  end

  // Result never exceeds full charge
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (charge <= FULL_CHARGE))
    else $error("charge above full scale");

  // Input only backs up once the output is held
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // Quotient estimate is low by at most one
  assert property (@(posedge clk) disable iff (rst)
    s5_valid |-> ((s5_back <= s5_prod) && (rem < (PROD_W'(s5_width) << 1))))
    else $error("reciprocal estimate out of range");

  // Held output does not lose its transaction
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule
